>>> rtl/core/assert_macros.svh
// Assertion macros used by multi_level_priority_queue.sv.
// Depends on nothing; simulation-only bodies are dropped when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/mlpq_pkg.sv
// Shared types and constants of the multi-level priority queue.
// No dependencies.
`default_nettype none
package mlpq_pkg;
   localparam int MAX_LEVELS = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_GET    = 1'b1;

   localparam logic [1:0] RSN_NONE  = 2'd0;
   localparam logic [1:0] RSN_RANGE = 2'd1;
   localparam logic [1:0] RSN_FULL  = 2'd2;

   localparam logic [7:0] CSR_ACTIVE_ADDR = 8'h00;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // latch request, start phase 1
      logic commit;    // phase 2: write back and build result
      logic peek;      // phase 3: read the new head value
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic busy;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_PEEK = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;
endpackage
`default_nettype wire

>>> rtl/core/multi_level_priority_queue.sv
// Channel  | Dir | Content
// req      | in  | tdata: value[31:0], priority_req[35:32]; tuser: op
// rsp      | out | tdata: reason[1:0], popped_value, popped_priority, head fields
// csr      | in  | APB, active_priorities at 0x0
// An item is worked in order after it is taken: classify and memory read,
// write-back, then the head value read; the result is then held on rsp.
// The next request is taken at the edge the result is delivered, so a new
// item is never taken before the last result has gone. Synchronous reset
// empties every level; an rsp stall holds the result and keeps req_tready low.
// Depends on mlpq_pkg, mlpq_ctrl, mlpq_dpath, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module multi_level_priority_queue #(
   parameter int CAPACITY   = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value[31:0], priority_req[35:32], zero pad
   input  wire logic        req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // rejected_reason[1:0], popped_value[33:2],
                                         // popped_priority[37:34], head_valid[38],
                                         // head_value[70:39], head_priority[74:71]
   output logic             rsp_tuser,   // accepted
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [4:0] active_ff;
   mlpq_pkg::cmd_type cmd;
   mlpq_pkg::sts_type sts;
   logic acc;
   logic [1:0] rsn;
   logic [31:0] pv, hv;
   logic [3:0] pp, hp;
   logic hvld;

   // register port
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) active_ff <= 5'd16;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         active_ff <= csr_pwdata[4:0];
   end
   assign csr_prdata = (csr_paddr == 2'd0) ? {27'd0, active_ff} : 32'd0;

   mlpq_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .sts
   );

   mlpq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock, .reset, .cmd, .sts,
      .in_op(req_tuser), .in_value(req_tdata[31:0]), .in_prio(req_tdata[35:32]),
      .active_prio(active_ff),
      .o_accepted(acc), .o_reason(rsn), .o_pop_value(pv), .o_pop_prio(pp),
      .o_head_valid(hvld), .o_head_value(hv), .o_head_prio(hp)
   );

   assign rsp_tuser = acc;
   assign rsp_tdata = {5'd0, hp, hv, hvld, pp, pv, rsn};

   `ASSERT_IMPLY(a_no_acc_reason, clock, reset, rsp_tvalid && acc, rsn == mlpq_pkg::RSN_NONE)
   `ASSERT_IMPLY(a_head_zero, clock, reset, rsp_tvalid && !hvld, hp == 4'd0)
   `ASSERT_NEXT(a_take_exec, clock, reset, req_tvalid && req_tready, !rsp_tvalid)
endmodule
`default_nettype wire

>>> rtl/core/mlpq_ctrl.sv
// Controller of the priority queue: sequences load, commit, peek and result hand-off.
// Depends on mlpq_pkg.
`default_nettype none
module mlpq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output mlpq_pkg::cmd_type     cmd,
   input  wire mlpq_pkg::sts_type sts
);
   mlpq_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlpq_pkg::ST_IDLE: if (req_tvalid) state_in = mlpq_pkg::ST_EXEC;
         mlpq_pkg::ST_EXEC: state_in = mlpq_pkg::ST_PEEK;
         mlpq_pkg::ST_PEEK: state_in = mlpq_pkg::ST_OUT;
         mlpq_pkg::ST_OUT: begin
            if (rsp_tready) state_in = req_tvalid ? mlpq_pkg::ST_EXEC : mlpq_pkg::ST_IDLE;
         end
         default: state_in = mlpq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mlpq_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // next request taken while the result drains
   assign req_tready = !sts.busy && ((state_ff == mlpq_pkg::ST_IDLE) ||
                       ((state_ff == mlpq_pkg::ST_OUT) && rsp_tready));
   assign rsp_tvalid = (state_ff == mlpq_pkg::ST_OUT);
   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.commit = (state_ff == mlpq_pkg::ST_EXEC);
   assign cmd.peek   = (state_ff == mlpq_pkg::ST_PEEK);
endmodule
`default_nettype wire

>>> rtl/core/mlpq_dpath.sv
// Datapath of the priority queue: node store, free stack, level tables.
// Depends on mlpq_pkg.
`default_nettype none
module mlpq_dpath #(
   parameter int CAPACITY   = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mlpq_pkg::cmd_type cmd,
   output mlpq_pkg::sts_type      sts,
   input  wire logic              in_op,
   input  wire logic [31:0]       in_value,
   input  wire logic [3:0]        in_prio,
   input  wire logic [4:0]        active_prio,
   output logic                   o_accepted,
   output logic [1:0]             o_reason,
   output logic [31:0]            o_pop_value,
   output logic [3:0]             o_pop_prio,
   output logic                   o_head_valid,
   output logic [31:0]            o_head_value,
   output logic [3:0]             o_head_prio
);
   localparam int MAX_LEVELS = mlpq_pkg::MAX_LEVELS;
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(MAX_LEVELS);
   localparam int CW = $clog2(CAPACITY + 1);

   // memories
   logic [31:0] value_mem [CAPACITY];
   logic [AW-1:0] link_mem [CAPACITY];
   logic [AW-1:0] free_mem [CAPACITY];

   logic [AW-1:0] first_ff [MAX_LEVELS];
   logic [AW-1:0] last_ff  [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] nonempty_ff;
   logic [CW-1:0] count_ff;
   logic [CAPACITY-1:0] free_init_ff;  // free entry never written: reads its index
   logic [31:0] head_value_ff;

   // latched request
   logic          op_ff;
   logic [31:0]   val_ff;
   logic [LW-1:0] lvl_ff;
   logic          ok_ff;
   logic [1:0]    rsn_ff;

   // read data registered in phase 1
   logic [AW-1:0] free_rd_ff, link_rd_ff;
   logic [31:0]   pop_rd_ff;

   // lowest nonempty level (priority encoder over level bits)
   logic [LW-1:0] low_lv;
   logic          any_ne;
   always_comb begin
      low_lv = '0;
      any_ne = 1'b0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            low_lv = LW'(i);
            any_ne = 1'b1;
         end
      end
   end

   // limit check
   logic [8:0] limit;
   logic       in_range;
   always_comb begin
      limit = (9'(active_prio) > 9'(MAX_LEVELS)) ? 9'(MAX_LEVELS) : 9'(active_prio);
      in_range = 9'(in_prio) < limit;
   end

   logic [AW-1:0] cnt_idx;
   logic [AW-1:0] pop_slot;
   assign cnt_idx  = count_ff[AW-1:0];
   assign pop_slot = first_ff[low_lv];

   // phase 1: classify and read memories
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= in_op;
         val_ff <= in_value;
         lvl_ff <= LW'(in_prio);
         if (in_op == mlpq_pkg::OP_INSERT) begin
            ok_ff  <= in_range && (32'(count_ff) < CAPACITY);
            rsn_ff <= !in_range ? mlpq_pkg::RSN_RANGE :
                      (32'(count_ff) < CAPACITY) ? mlpq_pkg::RSN_NONE : mlpq_pkg::RSN_FULL;
         end else begin
            ok_ff  <= any_ne;
            rsn_ff <= any_ne ? mlpq_pkg::RSN_NONE : mlpq_pkg::RSN_FULL;
         end
         free_rd_ff <= free_init_ff[cnt_idx] ? cnt_idx : free_mem[cnt_idx];
         link_rd_ff <= link_mem[pop_slot];
         pop_rd_ff  <= value_mem[pop_slot];
      end
   end

   // phase 2: memory writes
   logic [AW-1:0] ins_slot;
   logic [LW-1:0] pop_lv_ff;
   assign ins_slot = free_rd_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) pop_lv_ff <= low_lv;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ok_ff) begin
         if (op_ff == mlpq_pkg::OP_INSERT) begin
            value_mem[ins_slot] <= val_ff;
         end else begin
            free_mem[AW'(count_ff - 1'b1)] <= first_ff[pop_lv_ff];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.commit && ok_ff && op_ff == mlpq_pkg::OP_INSERT && nonempty_ff[lvl_ff])
         link_mem[last_ff[lvl_ff]] <= ins_slot;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff  <= '0;
         count_ff     <= '0;
         free_init_ff <= '1;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            first_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
      end else if (cmd.commit && ok_ff) begin
         if (op_ff == mlpq_pkg::OP_INSERT) begin
            count_ff <= count_ff + 1'b1;
            if (!nonempty_ff[lvl_ff]) first_ff[lvl_ff] <= ins_slot;
            last_ff[lvl_ff]     <= ins_slot;
            nonempty_ff[lvl_ff] <= 1'b1;
         end else begin
            count_ff <= count_ff - 1'b1;
            free_init_ff[AW'(count_ff - 1'b1)] <= 1'b0;
            if (first_ff[pop_lv_ff] == last_ff[pop_lv_ff]) nonempty_ff[pop_lv_ff] <= 1'b0;
            else first_ff[pop_lv_ff] <= link_rd_ff;
         end
      end
   end

   // result fields, captured at commit
   logic r_ok;
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         r_ok        <= ok_ff;
         o_reason    <= rsn_ff;
         o_pop_value <= (ok_ff && op_ff == mlpq_pkg::OP_GET) ? pop_rd_ff : 32'd0;
         o_pop_prio  <= (ok_ff && op_ff == mlpq_pkg::OP_GET) ? 4'(pop_lv_ff) : 4'd0;
      end
   end
   assign o_accepted = r_ok;

   // phase 3: head value read over the updated tables
   always_ff @(posedge clock) begin
      if (cmd.peek) head_value_ff <= value_mem[first_ff[low_lv]];
   end

   // head peek, stable while the result waits
   always_comb begin
      o_head_valid = any_ne;
      o_head_value = any_ne ? head_value_ff : 32'd0;
      o_head_prio  = any_ne ? 4'(low_lv) : 4'd0;
   end

   assign sts.busy = 1'b0;
endmodule
`default_nettype wire
